/* rtl/ird_pkg.sv */
// shared types and constants for the io range decoder
// used by ird_ctrl, ird_datapath and io_range_decoder; no dependencies
package ird_pkg;

    localparam int ADDR_W  = 64;
    localparam int LEN_W   = 32;
    localparam int OWNER_W = 8;
    localparam int SIZE_W  = 4;
    localparam int STAT_W  = 3;
    localparam int FILL_W  = 8;

    // one table entry as stored in ram: {owner, length, base}
    localparam int ENTRY_W = ADDR_W + LEN_W + OWNER_W;

    // input word: tdata = {pad, access_size, wr_flag, owner_id, range_length, address}
    localparam int IN_DATA_W  = 112;
    localparam int IN_USER_W  = 3;
    // output word: tdata = {pad, fill_length, fill_byte, fill_data, offset, hit_owner}
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USER_W = 3;

    localparam logic [1:0] REQ_ACCESS   = 2'd0;
    localparam logic [1:0] REQ_REGISTER = 2'd1;
    localparam logic [1:0] REQ_REMOVE   = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STATUS_OVERLAP   = 3'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] STATUS_UNHANDLED = 3'd3;
    localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 3'd4;

    localparam logic [FILL_W-1:0] FILL_PORT = 8'hFF;
    localparam logic [FILL_W-1:0] FILL_MEM  = 8'h00;
    localparam logic [SIZE_W-1:0] MAX_FILL  = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } ird_state_t;

    typedef struct packed {
        logic capture;
        logic check;
        logic finish;
    } ird_cmd_t;

    typedef struct packed {
        logic stop;
        logic last;
        logic out_busy;
    } ird_stat_t;

endpackage

/* rtl/io_range_decoder.sv */
// top level of the io range decoder: stream ports, controller and datapath
// depends on ird_pkg, ird_ctrl, ird_datapath
//
// Keeps two tables of ENTRIES_PER_SPACE address ranges, one for port space
// and one for memory space, each entry a base, a length and an owner. A
// request registers a range, removes one, or looks up an access and returns
// the owner and offset, or on a miss how to fill the data. Entries live in
// a single ram that is scanned one entry at a time (address, then compare):
// a lookup or remove stops at its first match, a register request visits
// all ENTRIES_PER_SPACE entries of its space, and an unused request type
// visits one. A finished result waits in an output register while the next
// word is accepted; the finish step of an item is held for as long as the
// previous result is still waiting there.
module io_range_decoder
    import ird_pkg::*;
#(
    parameter int ENTRIES_PER_SPACE = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // address, range_length, owner_id, wr_flag, access_size, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type, space
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // hit_owner, offset, fill_data, fill_byte, fill_length, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    ird_cmd_t  cmd;
    ird_stat_t st;

    ird_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ird_datapath #(
        .ENTRIES_PER_SPACE (ENTRIES_PER_SPACE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

/* rtl/ird_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module ird_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ird_ctrl.sv */
// sequencer for the range decoder: accept, scan entries, emit result
// depends on ird_pkg
module ird_ctrl
    import ird_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ird_stat_t st,
    output ird_cmd_t  cmd
);

    ird_state_t state_reg;
    ird_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (st.stop || st.last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_FINISH:
            begin
                if (!st.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // scan never runs past the last entry of a table
    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && (st.stop || st.last)) |=> state_reg == ST_FINISH)
        else $error("scan continued past its end");

endmodule

/* rtl/ird_datapath.sv */
// request registers, range table ram, valid bits, range compare and output register
// depends on ird_pkg and ird_ram
module ird_datapath
    import ird_pkg::*;
#(
    parameter int ENTRIES_PER_SPACE = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ird_cmd_t              cmd,
    output ird_stat_t             st,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic [IN_USER_W-1:0]  in_user,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic [OUT_USER_W-1:0] out_user
);

    localparam int IDX_W  = (ENTRIES_PER_SPACE > 1) ? $clog2(ENTRIES_PER_SPACE) : 1;
    localparam int SLOTS  = 2 * ENTRIES_PER_SPACE;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(ENTRIES_PER_SPACE - 1);
    localparam logic [SLOT_W-1:0] MEM_OFFSET = SLOT_W'(ENTRIES_PER_SPACE);

    // captured request
    logic [1:0]         req_reg;
    logic               space_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic               wr_reg;
    logic [SIZE_W-1:0]  size_reg;

    // scan state
    logic [IDX_W-1:0]   idx_reg;
    logic               found_reg;
    logic               clash_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [OWNER_W-1:0] hit_owner_reg;
    logic [ADDR_W-1:0]  offset_reg;
    logic [SLOTS-1:0]   valid_reg;

    // output register
    logic               out_valid_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [OWNER_W-1:0] out_owner_reg;
    logic [ADDR_W-1:0]  out_offset_reg;
    logic               out_fill_reg;
    logic [FILL_W-1:0]  out_fbyte_reg;
    logic [SIZE_W-1:0]  out_flen_reg;

    logic [SLOT_W-1:0]  space_base;
    logic [SLOT_W-1:0]  cur_slot;
    logic [SLOT_W-1:0]  free_slot;
    logic [ENTRY_W-1:0] rdata;
    logic [ADDR_W-1:0]  e_base;
    logic [LEN_W-1:0]   e_len;
    logic [OWNER_W-1:0] e_owner;
    logic               e_valid;
    logic [ADDR_W:0]    d_addr;
    logic [ADDR_W:0]    d_base;
    logic               addr_in_entry;
    logic               base_in_new;
    logic               acc_hit;
    logic               rm_match;
    logic               clash_now;
    logic               ram_we;
    logic               stop_now;

    logic [STAT_W-1:0]  res_status;
    logic [OWNER_W-1:0] res_owner;
    logic [ADDR_W-1:0]  res_offset;
    logic               res_fill;
    logic [FILL_W-1:0]  res_fbyte;
    logic [SIZE_W-1:0]  res_flen;

    // port table in the low slots, memory table above it
    assign space_base = space_reg ? MEM_OFFSET : '0;
    assign cur_slot   = space_base + SLOT_W'(idx_reg);
    assign free_slot  = space_base + SLOT_W'(free_idx_reg);

    assign ram_we = cmd.finish && (req_reg == REQ_REGISTER) && !clash_reg && free_found_reg;

    ird_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_slot),
        .wdata ({owner_reg, len_reg, addr_reg}),
        .raddr (cur_slot),
        .rdata (rdata)
    );

    assign e_base  = rdata[ADDR_W-1:0];
    assign e_len   = rdata[ADDR_W+LEN_W-1:ADDR_W];
    assign e_owner = rdata[ENTRY_W-1:ADDR_W+LEN_W];
    assign e_valid = valid_reg[cur_slot];

    // borrow bit says the minuend was below the subtrahend
    assign d_addr = {1'b0, addr_reg} - {1'b0, e_base};
    assign d_base = {1'b0, e_base} - {1'b0, addr_reg};

    assign addr_in_entry = !d_addr[ADDR_W] && (d_addr[ADDR_W-1:0] < {32'b0, e_len});
    assign base_in_new   = !d_base[ADDR_W] && (d_base[ADDR_W-1:0] < {32'b0, len_reg});

    assign acc_hit   = e_valid && addr_in_entry;
    assign rm_match  = e_valid && (e_owner == owner_reg) && (e_base == addr_reg);
    assign clash_now = e_valid && (e_len != '0) && (len_reg != '0)
                       && (addr_in_entry || base_in_new);

    always_comb
    begin
        case (req_reg)
            REQ_ACCESS:   stop_now = acc_hit;
            REQ_REGISTER: stop_now = 1'b0;
            REQ_REMOVE:   stop_now = rm_match;
            default:      stop_now = 1'b1;
        endcase
    end
    assign st.stop     = stop_now;
    assign st.last     = (idx_reg == LAST_IDX);
    assign st.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= in_user[1:0];
            space_reg <= in_user[2];
            addr_reg  <= in_data[63:0];
            len_reg   <= in_data[95:64];
            owner_reg <= in_data[103:96];
            wr_reg    <= in_data[104];
            size_reg  <= in_data[108:105];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            clash_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            hit_owner_reg  <= '0;
            offset_reg     <= '0;
            valid_reg      <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                idx_reg        <= '0;
                found_reg      <= 1'b0;
                clash_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (cmd.check)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                case (req_reg)
                    REQ_ACCESS:
                    begin
                        if (acc_hit)
                        begin
                            found_reg     <= 1'b1;
                            hit_owner_reg <= e_owner;
                            offset_reg    <= d_addr[ADDR_W-1:0];
                        end
                    end
                    REQ_REGISTER:
                    begin
                        if (clash_now)
                        begin
                            clash_reg <= 1'b1;
                        end
                        if (!e_valid && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= idx_reg;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (rm_match)
                        begin
                            found_reg           <= 1'b1;
                            valid_reg[cur_slot] <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (ram_we)
            begin
                valid_reg[free_slot] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        res_status = STATUS_OK;
        res_owner  = '0;
        res_offset = '0;
        res_fill   = 1'b0;
        res_fbyte  = '0;
        res_flen   = '0;
        case (req_reg)
            REQ_ACCESS:
            begin
                if (found_reg)
                begin
                    res_owner  = hit_owner_reg;
                    res_offset = offset_reg;
                end
                else
                begin
                    res_status = STATUS_UNHANDLED;
                    // port space fills always, memory space only on reads
                    res_fill   = !space_reg || !wr_reg;
                    res_fbyte  = space_reg ? FILL_MEM : FILL_PORT;
                    if (res_fill)
                    begin
                        res_flen = (size_reg > MAX_FILL) ? MAX_FILL : size_reg;
                    end
                end
            end
            REQ_REGISTER:
            begin
                if (clash_reg)
                begin
                    res_status = STATUS_OVERLAP;
                end
                else if (!free_found_reg)
                begin
                    res_status = STATUS_FULL;
                end
            end
            REQ_REMOVE:
            begin
                res_status = found_reg ? STATUS_OK : STATUS_NOT_FOUND;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_status_reg <= res_status;
            out_owner_reg  <= res_owner;
            out_offset_reg <= res_offset;
            out_fill_reg   <= res_fill;
            out_fbyte_reg  <= res_fbyte;
            out_flen_reg   <= res_flen;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_user  = out_status_reg;
    assign out_data  = {3'b000, out_flen_reg, out_fbyte_reg, out_fill_reg,
                        out_offset_reg, out_owner_reg};

    // a result never lands on a word that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten");

    // a new range only goes into a free slot
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !valid_reg[free_slot])
        else $error("range written over a live entry");

    // a matched remove frees its slot
    a_remove_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.check && (req_reg == REQ_REMOVE) && rm_match) |=> !valid_reg[$past(cur_slot)])
        else $error("removed entry still valid");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(found_reg && clash_reg))
        else $error("hit and overlap flagged together");

endmodule

/* bench/tb_io_range_decoder.sv */
`timescale 1ns / 1ps
// testbench for io_range_decoder: directed and random register, remove and lookup traffic
// depends on ird_pkg and the io_range_decoder rtl; predicts every result word in-line
module tb_io_range_decoder;
    import ird_pkg::*;

    localparam int ENTRIES = 16;
    localparam int TOTAL_SLOTS = 2 * ENTRIES;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 400;
    // one register request scans a whole space
    localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;

    typedef struct {
        logic [1:0]         req;
        logic               sp;
        logic [ADDR_W-1:0]  addr;
        logic [LEN_W-1:0]   len;
        logic [OWNER_W-1:0] owner;
        logic               wr;
        logic [SIZE_W-1:0]  size;
    } req_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [OWNER_W-1:0] hit_owner;
        logic [ADDR_W-1:0]  offset;
        logic               fill_data;
        logic [FILL_W-1:0]  fill_byte;
        logic [SIZE_W-1:0]  fill_length;
    } result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // address, range_length, owner_id, wr_flag, access_size, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // req_type, space
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // hit_owner, offset, fill_data, fill_byte, fill_length, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // status
    logic [OUT_USER_W-1:0] m_axis_tuser;

    // shadow copy of both range tables
    logic [ADDR_W-1:0]  tbl_base  [TOTAL_SLOTS];
    logic [LEN_W-1:0]   tbl_len   [TOTAL_SLOTS];
    logic [OWNER_W-1:0] tbl_owner [TOTAL_SLOTS];
    logic               tbl_valid [TOTAL_SLOTS];

    result_t pending_results[$];
    int      errors = 0;
    int      burst_left = 0;
    int      hold_req_cnt = 0;
    int      hold_ack_cnt = 0;
    int      hold_left = 0;
    int      rx_mode = 0;
    int      rx_mode_left = 0;

    io_range_decoder #(
        .ENTRIES_PER_SPACE(ENTRIES)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // no wrap: a range may run past the top of the address space
    function automatic logic covers(logic [ADDR_W-1:0] base, logic [LEN_W-1:0] len,
                                    logic [ADDR_W-1:0] x);
        return (x >= base) && ((x - base) < {32'd0, len});
    endfunction

    function automatic logic ranges_clash(logic [ADDR_W-1:0] a, logic [LEN_W-1:0] la,
                                          logic [ADDR_W-1:0] b, logic [LEN_W-1:0] lb);
        if (la == '0 || lb == '0)
            return 1'b0;
        return covers(b, lb, a) || covers(a, la, b);
    endfunction

    function automatic result_t decode_request(input req_item_t it);
        result_t r;
        int      first;
        int      s;
        int      free_slot;
        logic    clash;
        logic    hit;
        r = '0;
        first = it.sp ? ENTRIES : 0;
        free_slot = -1;
        clash = 1'b0;
        hit = 1'b0;
        case (it.req)
            REQ_ACCESS:
            begin
                for (s = first; s < first + ENTRIES && !hit; s++)
                begin
                    if (tbl_valid[s] && covers(tbl_base[s], tbl_len[s], it.addr))
                    begin
                        hit = 1'b1;
                        r.hit_owner = tbl_owner[s];
                        r.offset = it.addr - tbl_base[s];
                    end
                end
                if (!hit)
                begin
                    r.status = STATUS_UNHANDLED;
                    if (!it.sp)
                    begin
                        r.fill_data = 1'b1;
                        r.fill_byte = FILL_PORT;
                    end
                    else if (!it.wr)
                    begin
                        r.fill_data = 1'b1;
                        r.fill_byte = FILL_MEM;
                    end
                    if (r.fill_data)
                        r.fill_length = (it.size > MAX_FILL) ? MAX_FILL : it.size;
                end
            end
            REQ_REGISTER:
            begin
                for (s = first; s < first + ENTRIES; s++)
                begin
                    if (tbl_valid[s])
                    begin
                        if (ranges_clash(tbl_base[s], tbl_len[s], it.addr, it.len))
                            clash = 1'b1;
                    end
                    else if (free_slot < 0)
                        free_slot = s;
                end
                if (clash)
                    r.status = STATUS_OVERLAP;
                else if (free_slot < 0)
                    r.status = STATUS_FULL;
                else
                begin
                    tbl_base[free_slot] = it.addr;
                    tbl_len[free_slot] = it.len;
                    tbl_owner[free_slot] = it.owner;
                    tbl_valid[free_slot] = 1'b1;
                end
            end
            REQ_REMOVE:
            begin
                r.status = STATUS_NOT_FOUND;
                for (s = first; s < first + ENTRIES && !hit; s++)
                begin
                    if (tbl_valid[s] && tbl_owner[s] == it.owner && tbl_base[s] == it.addr)
                    begin
                        tbl_valid[s] = 1'b0;
                        r.status = STATUS_OK;
                        hit = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic req_item_t mk(logic [1:0] req, logic sp, logic [63:0] addr,
                                     logic [31:0] len, logic [7:0] owner, logic wr,
                                     logic [3:0] size);
        req_item_t it;
        it.req = req;
        it.sp = sp;
        it.addr = addr;
        it.len = len;
        it.owner = owner;
        it.wr = wr;
        it.size = size;
        return it;
    endfunction

    function automatic int pick_entry(input logic sp);
        int cand[$];
        int s;
        int first;
        first = sp ? ENTRIES : 0;
        for (s = first; s < first + ENTRIES; s++)
            if (tbl_valid[s])
                cand.insert(cand.size(), s);
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    // mostly well-formed traffic aimed at live ranges, some noise
    function automatic req_item_t random_request();
        req_item_t   it;
        int          kind;
        int          slot;
        logic [63:0] win;
        logic [63:0] span;
        kind = $urandom_range(0, 99);
        it = mk(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), rand64(), $urandom,
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                4'($urandom_range(0, 15)));
        case ($urandom_range(0, 3))
            0: win = 64'h0;
            1: win = 64'h0000_0000_1000_0000;
            2: win = 64'hFFFF_FFFF_FFFF_F000;
            default: win = rand64() & ~64'hFFF;
        endcase
        if (kind < 40)
        begin
            it.req = REQ_ACCESS;
            slot = pick_entry(it.sp);
            if (slot >= 0 && $urandom_range(0, 3) != 0)
            begin
                span = {32'd0, tbl_len[slot]} + 64'd2;
                if ($urandom_range(0, 9) == 0)
                    it.addr = tbl_base[slot] - 64'd1;
                else
                    it.addr = tbl_base[slot] + (rand64() % span);
            end
            else if ($urandom_range(0, 1) == 0)
                it.addr = win + 64'($urandom_range(0, 'h4FF));
        end
        else if (kind < 72)
        begin
            it.req = REQ_REGISTER;
            it.addr = win + 64'($urandom_range(0, 'h3FF));
            case ($urandom_range(0, 9))
                0: it.len = '0;
                1: ;
                default: it.len = $urandom_range(1, 'h80);
            endcase
        end
        else if (kind < 96)
        begin
            it.req = REQ_REMOVE;
            slot = pick_entry(it.sp);
            if (slot >= 0 && $urandom_range(0, 3) != 0)
            begin
                it.addr = tbl_base[slot];
                it.owner = tbl_owner[slot];
                // wrong owner on a live base now and then
                if ($urandom_range(0, 7) == 0)
                    it.owner = tbl_owner[slot] ^ 8'h01;
            end
        end
        return it;
    endfunction

    // call at a rising edge; returns at the edge that accepts the word
    task automatic send_word(input req_item_t it);
        int   gap;
        logic took;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'd0, it.size, it.wr, it.owner, it.len, it.addr};
        s_axis_tuser <= {it.sp, it.req};
        do
        begin
            @(negedge clk);
            took = s_axis_tready;
            @(posedge clk);
        end while (!took);
        pending_results.insert(pending_results.size(), decode_request(it));
        burst_left--;
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_miss_fill();
        send_word(mk(REQ_ACCESS, 1'b0, 64'h0, '0, '0, 1'b0, 4'd1));
        send_word(mk(REQ_ACCESS, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, 1'b0, 4'd8));
        send_word(mk(REQ_ACCESS, 1'b1, 64'h1234, '1, '1, 1'b1, 4'd4));
        // sizes beyond 8 saturate, size 0 fills nothing
        send_word(mk(REQ_ACCESS, 1'b0, 64'h8000_0000_0000_0000, '0, '0, 1'b1, 4'd15));
        send_word(mk(REQ_ACCESS, 1'b0, 64'h55, '0, '0, 1'b0, 4'd0));
        send_word(mk(REQ_ACCESS, 1'b1, 64'h55, '0, '0, 1'b0, 4'd9));
    endtask

    task automatic test_unused_request();
        send_word(mk(REQ_UNUSED, 1'b1, '1, '1, '1, 1'b1, '1));
        send_word(mk(REQ_UNUSED, 1'b0, '0, '0, '0, 1'b0, '0));
    endtask

    task automatic test_ranges();
        send_word(mk(REQ_REGISTER, 1'b0, 64'h1000, 32'h100, 8'h11, 1'b0, 4'd1));
        send_word(mk(REQ_REGISTER, 1'b0, 64'h10FF, 32'h1, 8'h22, 1'b0, 4'd1));
        send_word(mk(REQ_REGISTER, 1'b0, 64'h1100, 32'h10, 8'h22, 1'b0, 4'd1));
        send_word(mk(REQ_ACCESS, 1'b0, 64'h10FF, '0, '0, 1'b0, 4'd2));
        send_word(mk(REQ_ACCESS, 1'b0, 64'h1100, '0, '0, 1'b1, 4'd2));
        send_word(mk(REQ_ACCESS, 1'b1, 64'h1000, '0, '0, 1'b0, 4'd2));
        // range running past the top of the address space
        send_word(mk(REQ_REGISTER, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0, '1, 8'hFF, 1'b0, 4'd1));
        send_word(mk(REQ_ACCESS, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, 1'b0, 4'd8));
        // zero length ranges take a slot, never clash and never hit
        send_word(mk(REQ_REGISTER, 1'b1, 64'h0, '0, 8'h33, 1'b0, 4'd1));
        send_word(mk(REQ_REGISTER, 1'b1, 64'h0, '0, 8'h33, 1'b0, 4'd1));
        send_word(mk(REQ_ACCESS, 1'b1, 64'h0, '0, '0, 1'b0, 4'd3));
        send_word(mk(REQ_REGISTER, 1'b0, 64'h1000, '1, 8'h44, 1'b0, 4'd1));
    endtask

    task automatic test_remove();
        send_word(mk(REQ_REMOVE, 1'b1, 64'h0, '0, 8'h33, 1'b0, 4'd1));
        send_word(mk(REQ_REMOVE, 1'b1, 64'h0, '0, 8'h33, 1'b0, 4'd1));
        send_word(mk(REQ_REMOVE, 1'b1, 64'h0, '0, 8'h33, 1'b0, 4'd1));
        send_word(mk(REQ_REMOVE, 1'b0, 64'h1000, '0, 8'h22, 1'b0, 4'd1));
        send_word(mk(REQ_REMOVE, 1'b0, 64'h1000, '0, 8'h11, 1'b0, 4'd1));
        send_word(mk(REQ_REMOVE, 1'b0, 64'h1100, '0, 8'h22, 1'b0, 4'd1));
        send_word(mk(REQ_REMOVE, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0, '0, 8'hFF, 1'b0, 4'd1));
    endtask

    task automatic test_table_full();
        logic [63:0] region;
        int          sp;
        int          i;
        int          s;
        for (sp = 0; sp < 2; sp++)
        begin
            for (s = sp * ENTRIES; s < (sp + 1) * ENTRIES; s++)
                if (tbl_valid[s])
                    send_word(mk(REQ_REMOVE, 1'(sp), tbl_base[s], '0, tbl_owner[s],
                                 1'b0, 4'd1));
            region = rand64() & ~64'hFFFF;
            for (i = 0; i < ENTRIES; i++)
                send_word(mk(REQ_REGISTER, 1'(sp), region + 64'(i * 'h40),
                             $urandom_range(0, 'h40), 8'($urandom_range(0, 255)),
                             1'b0, 4'd1));
            // overlap is reported ahead of a full table
            send_word(mk(REQ_REGISTER, 1'(sp), region, 32'h400, 8'h5A, 1'b0, 4'd1));
            send_word(mk(REQ_REGISTER, 1'(sp), region + 64'h10000, 32'h1, 8'h5A, 1'b0, 4'd1));
            for (i = 0; i < 8; i++)
                send_word(mk(REQ_ACCESS, 1'(sp), region + 64'($urandom_range(0, 'h420)),
                             $urandom, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 4'($urandom_range(0, 15))));
            for (s = sp * ENTRIES; s < (sp + 1) * ENTRIES; s += 2)
                if (tbl_valid[s])
                    send_word(mk(REQ_REMOVE, 1'(sp), tbl_base[s], '0, tbl_owner[s],
                                 1'b0, 4'd1));
        end
    endtask

    task automatic test_backpressure();
        hold_req_cnt <= hold_req_cnt + 1;
        repeat (30) send_word(random_request());
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_word(random_request());
    endtask

    // result side: long hold-offs on request, otherwise a changing stall mix
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_ack_cnt != hold_req_cnt)
        begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode <= $urandom_range(0, 2);
                rx_mode_left <= $urandom_range(20, 200);
            end
            else
                rx_mode_left <= rx_mode_left - 1;
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // outputs are stable at the falling edge; the word moves at the next rising edge
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %h/%h",
                         $time, m_axis_tuser, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, m_axis_tuser[2:0]);
                check_field("hit_owner", want.hit_owner, m_axis_tdata[7:0]);
                check_field("offset", want.offset, m_axis_tdata[71:8]);
                check_field("fill_data", want.fill_data, m_axis_tdata[72]);
                check_field("fill_byte", want.fill_byte, m_axis_tdata[80:73]);
                check_field("fill_length", want.fill_length, m_axis_tdata[84:81]);
            end
        end
    end

    initial
    begin
        foreach (tbl_valid[s])
        begin
            tbl_valid[s] = 1'b0;
            tbl_base[s] = '0;
            tbl_len[s] = '0;
            tbl_owner[s] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_miss_fill();
        test_unused_request();
        test_ranges();
        test_remove();
        wait_for_results();
        test_table_full();
        wait_for_results();
        test_backpressure();
        wait_for_results();
        test_random_traffic(700);
        wait_for_results();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
